// ----- hdl/calendar_date_subtract_top_assert.svh -----
// Assertion macros used by the date subtraction back end.
// Clock and active-low reset are passed in; no other dependencies.
`ifndef CALENDAR_DATE_SUBTRACT_TOP_ASSERT_SVH
`define CALENDAR_DATE_SUBTRACT_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define CDS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CDS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define CDS_ASSERT(lbl, clk, rst_n, prop, msg)
`define CDS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

// ----- hdl/cds_pkg.sv -----
// Types, constants and calendar helper functions for the date subtraction block.
// No dependencies; used by every module of the block.
package cds_pkg;

  localparam int COUNT_W    = 10;
  localparam int COUNT_BITS = 10;
  localparam int STEP_W     = COUNT_BITS + 3;  // holds count * 7
  localparam int YEAR_W     = 16;
  localparam int QUOT_W     = 12;              // floor(65535 / 25) fits
  localparam int PROD_W     = 33;
  localparam int RES_W      = 5;

  // floor(u / 25) = (u * RECIP25) >> RECIP_SHIFT for every 16-bit u
  localparam logic [16:0]       RECIP25     = 17'd83887;
  localparam int                RECIP_SHIFT = 21;

  // Year residue tracked as (year + 32768) mod 25.
  localparam logic [RES_W-1:0]  RES_DIV25 = 5'd18;  // signed year divisible by 25
  localparam logic [RES_W-1:0]  RES_TOP   = 5'd24;
  localparam logic [RES_W-1:0]  RES_WRAP  = 5'd10;  // 65535 mod 25
  localparam logic [YEAR_W-1:0] YEAR_MIN  = 16'h8000;
  localparam logic [YEAR_W-1:0] YEAR_FLIP = 16'h8000;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;
  localparam logic [4:0] DAY_FIRST = 5'd1;
  localparam logic [4:0] FEB_LEAP  = 5'd29;

  localparam logic [4:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = 1;
  localparam int FIFO_CNT_W = 2;

  typedef enum logic [1:0] {
    OP_DAYS   = 2'd0,
    OP_WEEKS  = 2'd1,
    OP_MONTHS = 2'd2,
    OP_YEARS  = 2'd3
  } cds_op_e;

  typedef struct packed {
    cds_op_e                   op;
    logic [4:0]                day;
    logic [3:0]                month;
    logic signed [YEAR_W-1:0]  year;
    logic [COUNT_W-1:0]        count;
  } cds_in_t;

  typedef struct packed {
    logic [4:0]                new_day;
    logic [3:0]                new_month;
    logic signed [YEAR_W-1:0]  new_year;
  } cds_out_t;

  // Classified job handed from front to back.
  typedef struct packed {
    cds_op_e             op;
    logic [4:0]          day;
    logic [3:0]          month;
    logic [YEAR_W-1:0]   year;
    logic [RES_W-1:0]    res;
    logic [STEP_W-1:0]   steps;
  } cds_job_t;

  function automatic logic is_leap(logic [YEAR_W-1:0] year, logic [RES_W-1:0] res);
    logic div25;
    div25 = (res == RES_DIV25);
    return ((year[1:0] == 2'b00) && !div25) || ((year[3:0] == 4'b0000) && div25);
  endfunction

  function automatic logic [4:0] days_in(logic [3:0] month, logic leap);
    logic [3:0] idx;
    idx = month - MONTH_JAN;
    if (month == MONTH_FEB) begin
      return leap ? FEB_LEAP : MONTH_LEN[1];
    end
    return MONTH_LEN[idx];
  endfunction

endpackage

// ----- hdl/calendar_date_subtract_top.sv -----
// Path: an accepted word passes the front register and the queue into the back end, which
//   runs count steps for days and months, 7 * count for weeks, none for years, then registers it.
// Flow: the back end takes one word at a time through its one-step-per-cycle loop;
//   a two-entry queue lets the front take up to three more words meanwhile.
// Reset: asynchronous, active low; clears queue, valids and state, no clearing pass.
module calendar_date_subtract_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cds_pkg::cds_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cds_pkg::cds_out_t out_data_o
);
  import cds_pkg::*;

  logic     push, full, pop, empty;
  cds_job_t push_job, pop_job;

  cds_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .push_o      (push),
    .push_data_o (push_job),
    .full_i      (full)
  );

  cds_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .pop_data_o  (pop_job)
  );

  cds_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .job_i       (pop_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- hdl/cds_front.sv -----
// Front end: accepts request words, normalizes the date, sizes the step count
// and works out the year residue mod 25. Depends on cds_pkg.
module cds_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cds_pkg::cds_in_t  in_data_i,
  output logic              push_o,
  output cds_pkg::cds_job_t push_data_o,
  input  logic              full_i
);
  import cds_pkg::*;

  logic                s1_valid_q, s1_valid_d;
  cds_op_e             s1_op_q;
  logic [4:0]          s1_day_q;
  logic [3:0]          s1_month_q;
  logic [YEAR_W-1:0]   s1_year_q;
  logic [STEP_W-1:0]   s1_steps_q;
  logic [QUOT_W-1:0]   s1_quot_q;

  logic                accept;
  logic [3:0]          month_n;
  logic [4:0]          day_n;
  logic [YEAR_W-1:0]   ubias;
  logic [PROD_W-1:0]   prod;
  logic [STEP_W-1:0]   cnt_ext;
  logic [STEP_W-1:0]   steps;
  logic [YEAR_W-1:0]   quot_ext;
  logic [YEAR_W-1:0]   q25;
  logic [YEAR_W-1:0]   rem;

  assign in_ready_o = !s1_valid_q || !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = s1_valid_q && !full_i;

  always_comb begin
    month_n = in_data_i.month;
    if (in_data_i.month == 4'd0) begin
      month_n = MONTH_JAN;
    end else if (in_data_i.month > MONTH_DEC) begin
      month_n = MONTH_DEC;
    end
    day_n = (in_data_i.day == 5'd0) ? DAY_FIRST : in_data_i.day;
  end

  assign ubias   = YEAR_W'(in_data_i.year) ^ YEAR_FLIP;
  assign prod    = PROD_W'(ubias) * PROD_W'(RECIP25);
  assign cnt_ext = STEP_W'(in_data_i.count[COUNT_BITS-1:0]);

  always_comb begin
    case (in_data_i.op)
      OP_WEEKS: steps = STEP_W'(cnt_ext << 3) - cnt_ext;
      default:  steps = cnt_ext;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (push_o) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q    <= in_data_i.op;
      s1_day_q   <= day_n;
      s1_month_q <= month_n;
      s1_year_q  <= YEAR_W'(in_data_i.year);
      s1_steps_q <= steps;
      s1_quot_q  <= prod[RECIP_SHIFT +: QUOT_W];
    end
  end

  // Residue of the biased year: u - 25 * floor(u / 25)
  assign quot_ext = YEAR_W'(s1_quot_q);
  assign q25      = (quot_ext << 4) + (quot_ext << 3) + quot_ext;
  assign rem      = (s1_year_q ^ YEAR_FLIP) - q25;

  always_comb begin
    push_data_o.op    = s1_op_q;
    push_data_o.day   = s1_day_q;
    push_data_o.month = s1_month_q;
    push_data_o.year  = s1_year_q;
    push_data_o.res   = rem[RES_W-1:0];
    push_data_o.steps = s1_steps_q;
  end

endmodule

// ----- hdl/cds_fifo.sv -----
// Two-entry job queue between front and back.
// Depends on cds_pkg for the job type and depth.
module cds_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  cds_pkg::cds_job_t push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output cds_pkg::cds_job_t pop_data_o
);
  import cds_pkg::*;

  cds_job_t              mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d;
  logic                  do_push, do_pop;

  assign full_o     = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- hdl/cds_back.sv -----
// Back end: steps a date back one day or one month per cycle (years at load)
// and holds the result in an output register. Uses cds_pkg, assertion macros.
`include "calendar_date_subtract_top_assert.svh"

module cds_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  cds_pkg::cds_job_t  job_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output cds_pkg::cds_out_t  out_data_o
);
  import cds_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  state_e              state_q, state_d;
  logic                out_valid_q, out_valid_d;
  cds_out_t            out_q;
  cds_op_e             op_q;
  logic [4:0]          day_q, day_d;
  logic [3:0]          month_q, month_d;
  logic [YEAR_W-1:0]   year_q, year_d;
  logic [RES_W-1:0]    res_q, res_d;
  logic [STEP_W-1:0]   steps_q, steps_d;

  logic                slot_free, finish;
  logic [YEAR_W-1:0]   yr_dec;
  logic [RES_W-1:0]    res_dec;
  logic [3:0]          prev_m;
  logic [YEAR_W-1:0]   prev_y;
  logic [RES_W-1:0]    prev_r;
  logic [4:0]          prev_len;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign pop_o       = (state_q == ST_IDLE) && !empty_i;
  assign finish      = (state_q == ST_RUN) && (steps_q == '0) && slot_free;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Previous month, wrapping into December of the year before.
  always_comb begin
    yr_dec = year_q - 1'b1;
    if (res_q == '0) begin
      res_dec = (year_q == YEAR_MIN) ? RES_WRAP : RES_TOP;
    end else begin
      res_dec = res_q - 1'b1;
    end
    if (month_q == MONTH_JAN) begin
      prev_m = MONTH_DEC;
      prev_y = yr_dec;
      prev_r = res_dec;
    end else begin
      prev_m = month_q - 1'b1;
      prev_y = year_q;
      prev_r = res_q;
    end
    prev_len = days_in(prev_m, is_leap(prev_y, prev_r));
  end

  always_comb begin
    state_d = state_q;
    day_d   = day_q;
    month_d = month_q;
    year_d  = year_q;
    res_d   = res_q;
    steps_d = steps_q;
    case (state_q)
      ST_IDLE: begin
        if (pop_o) begin
          state_d = ST_RUN;
          day_d   = job_i.day;
          month_d = job_i.month;
          year_d  = job_i.year;
          res_d   = job_i.res;
          steps_d = job_i.steps;
          if (job_i.op == OP_YEARS) begin
            year_d  = job_i.year - YEAR_W'(job_i.steps);
            steps_d = '0;
          end
        end
      end
      ST_RUN: begin
        if (steps_q == '0) begin
          if (slot_free) begin
            state_d = ST_IDLE;
          end
        end else begin
          steps_d = steps_q - 1'b1;
          case (op_q)
            OP_MONTHS: begin
              month_d = prev_m;
              year_d  = prev_y;
              res_d   = prev_r;
              day_d   = (day_q > prev_len) ? prev_len : day_q;
            end
            default: begin
              if (day_q > DAY_FIRST) begin
                day_d = day_q - 1'b1;
              end else begin
                month_d = prev_m;
                year_d  = prev_y;
                res_d   = prev_r;
                day_d   = prev_len;
              end
            end
          endcase
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    day_q   <= day_d;
    month_q <= month_d;
    year_q  <= year_d;
    res_q   <= res_d;
    steps_q <= steps_d;
    if (pop_o) begin
      op_q <= job_i.op;
    end
    if (finish) begin
      out_q.new_day   <= day_q;
      out_q.new_month <= month_q;
      out_q.new_year  <= $signed(year_q);
    end
  end

  `CDS_ASSERT_NEVER(a_day_zero, clk_i, rst_ni, (state_q == ST_RUN) && (day_q == '0), "day reached zero")
  `CDS_ASSERT(a_month_range, clk_i, rst_ni, (state_q == ST_RUN) |-> ((month_q >= MONTH_JAN) && (month_q <= MONTH_DEC)), "month out of range")
  `CDS_ASSERT(a_res_range, clk_i, rst_ni, (state_q == ST_RUN) |-> (res_q <= RES_TOP), "year residue out of range")
  `CDS_ASSERT(a_countdown, clk_i, rst_ni, ((state_q == ST_RUN) && (steps_q != '0)) |=> ((state_q == ST_RUN) && (steps_q == $past(steps_q) - 1'b1)), "step counter skipped")

endmodule

// ----- test/calendar_date_subtract_top_tb.sv -----
// Self-checking testbench for calendar_date_subtract_top: drives date words with random
// idling on both channels and compares every output word against a behavioral predictor.
// Depends on cds_pkg for the word types and the operation codes.
module calendar_date_subtract_top_tb;
  import cds_pkg::*;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_ready_o;
  cds_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  cds_out_t out_data_o;

  cds_out_t pending_dates[$];
  int       bad_words   = 0;
  bit       idle_on     = 1'b0;
  int       stall_left  = 0;
  longint   cycle_count = 0;
  longint   cycle_limit = 10000;

  calendar_date_subtract_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic bit leap_year(logic [15:0] y16);
    int y;
    y = int'($signed(y16));
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int month_days(int m, logic [15:0] y16);
    if (m == 2) begin
      return leap_year(y16) ? 29 : 28;
    end
    if (m == 4 || m == 6 || m == 9 || m == 11) begin
      return 30;
    end
    return 31;
  endfunction

  function automatic cds_out_t predict_date(cds_in_t w);
    int          d, m, steps, i;
    logic [15:0] y;
    cds_out_t    r;
    d = int'(w.day);
    m = int'(w.month);
    y = w.year;
    if (m == 0) m = 1;
    if (m > 12) m = 12;
    if (d == 0) d = 1;
    case (w.op)
      OP_DAYS, OP_WEEKS: begin
        steps = (w.op == OP_WEEKS) ? int'(w.count) * 7 : int'(w.count);
        for (i = 0; i < steps; i++) begin
          if (d > 1) begin
            d--;
          end else if (m == 1) begin
            m = 12;
            d = 31;
            y = y - 16'd1;
          end else begin
            m--;
            d = month_days(m, y);
          end
        end
      end
      OP_MONTHS: begin
        for (i = 0; i < int'(w.count); i++) begin
          if (m == 1) begin
            m = 12;
            y = y - 16'd1;
          end else begin
            m--;
          end
          // the clamp carries over to later steps
          if (d > month_days(m, y)) d = month_days(m, y);
        end
      end
      default: begin
        y = y - 16'(w.count);
      end
    endcase
    r.new_day   = 5'(d);
    r.new_month = 4'(m);
    r.new_year  = y;
    return r;
  endfunction

  // Offer one word, with an optional idle burst first; valid stays high afterwards.
  task automatic send_word(cds_in_t w);
    int gap;
    int steps;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    case (w.op)
      OP_WEEKS: steps = int'(w.count) * 7;
      OP_YEARS: steps = 0;
      default:  steps = int'(w.count);
    endcase
    cycle_limit += 4 * (steps + 40);
    pending_dates.push_back(predict_date(w));
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_date(cds_op_e op, int d, int m, int y, int c);
    cds_in_t w;
    w.op    = op;
    w.day   = 5'(d);
    w.month = 4'(m);
    w.year  = 16'(y);
    w.count = 10'(c);
    send_word(w);
  endtask

  function automatic cds_in_t random_request();
    cds_in_t w;
    int      pick, y, m, len;
    w.op = cds_op_e'($urandom_range(0, 3));
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      y = $urandom_range(1500, 2500);
    end else if (pick < 65) begin
      y = int'($urandom_range(0, 65535)) - 32768;
    end else if (pick < 80) begin
      y = $urandom_range(0, 1) ? 32767 - int'($urandom_range(0, 40))
                               : -32768 + int'($urandom_range(0, 40));
    end else begin
      y = (int'($urandom_range(0, 600)) - 300) * 100 - int'($urandom_range(0, 1));
    end
    w.year = 16'(y);
    pick = $urandom_range(0, 99);
    if (w.op == OP_WEEKS) begin
      // keep long week runs rare, they cost seven steps per unit
      if (pick < 80)      w.count = 10'($urandom_range(0, 31));
      else if (pick < 98) w.count = 10'($urandom_range(0, 127));
      else                w.count = 10'($urandom_range(0, 1023));
    end else begin
      if (pick < 70)      w.count = 10'($urandom_range(0, 31));
      else if (pick < 90) w.count = 10'($urandom_range(0, 255));
      else                w.count = 10'($urandom_range(0, 1023));
    end
    if ($urandom_range(0, 99) < 88) begin
      m    = $urandom_range(1, 12);
      len  = month_days(m, w.year);
      pick = $urandom_range(0, 99);
      w.month = 4'(m);
      if (pick < 30)      w.day = 5'd1;
      else if (pick < 50) w.day = 5'(len);
      else                w.day = 5'($urandom_range(1, len));
    end else begin
      w.day   = 5'($urandom_range(0, 31));
      w.month = 4'($urandom_range(0, 15));
    end
    return w;
  endfunction

  // Field extremes, every operation, leap rules and year wrap.
  task automatic test_extremes();
    send_date(OP_DAYS,   1,  1,   2024,    1);
    send_date(OP_DAYS,   1,  3,   2000,    1);
    send_date(OP_DAYS,   1,  3,   1900,    1);
    send_date(OP_DAYS,   1,  3,   2024,    1);
    send_date(OP_DAYS,   1,  1, -32768,    1);
    send_date(OP_YEARS, 15,  6, -32768,    1);
    send_date(OP_YEARS, 31, 12,  32767, 1023);
    send_date(OP_MONTHS, 15, 1, -32768,    1);
    send_date(OP_WEEKS, 31, 12,  32767, 1023);
    send_date(OP_DAYS,  31, 12,      0, 1023);
    send_date(OP_MONTHS, 1,  1,      0, 1023);
    send_date(OP_WEEKS,  5,  3,   1600,    1);
    send_date(OP_DAYS,  31, 12,     -1,    0);
  endtask

  // Out-of-range fields, clamping and February 29 handling.
  task automatic test_special_cases();
    send_date(OP_YEARS,  29,  2, 2024,  1);
    send_date(OP_MONTHS, 31,  3, 2023,  1);
    send_date(OP_MONTHS, 31,  5, 2024,  3);
    send_date(OP_DAYS,   10,  0, 2020,  5);
    send_date(OP_DAYS,   10, 13, 2020,  5);
    send_date(OP_MONTHS, 10, 15, 2020,  2);
    send_date(OP_DAYS,    0,  4, 2020,  0);
    send_date(OP_DAYS,   31,  2, 2021, 40);
    send_date(OP_MONTHS, 31,  2, 2021,  1);
    send_date(OP_YEARS,  31,  4, 2021,  0);
  endtask

  task automatic test_random(int n, bit allow_idle);
    int i;
    for (i = 0; i < n; i++) begin
      if (i % 40 == 0) idle_on = allow_idle && ($urandom_range(0, 3) != 0);
      send_word(random_request());
    end
  endtask

  // Hold the sender until every result is back, then resume.
  task automatic test_drain_pause();
    int i;
    for (i = 0; i < 10; i++) send_word(random_request());
    in_valid_i <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // Receiver: check each accepted word, then decide ready for the next cycle.
  always @(posedge clk_i) begin
    cds_out_t exp_w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_dates.size() == 0) begin
        bad_words++;
        if (bad_words <= 10) begin
          $display("unexpected output word %0d-%0d-%0d", out_data_o.new_year,
                   out_data_o.new_month, out_data_o.new_day);
        end
      end else begin
        exp_w = pending_dates.pop_front();
        if (out_data_o.new_day !== exp_w.new_day || out_data_o.new_month !== exp_w.new_month ||
            out_data_o.new_year !== exp_w.new_year) begin
          bad_words++;
          if (bad_words <= 10) begin
            $display("mismatch: expected %0d-%0d-%0d got %0d-%0d-%0d",
                     exp_w.new_year, exp_w.new_month, exp_w.new_day,
                     out_data_o.new_year, out_data_o.new_month, out_data_o.new_day);
          end
        end
      end
    end
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (!idle_on) begin
      out_ready_i <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 10);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > cycle_limit) begin
      $display("[calendar_date_subtract_top] ERROR");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    idle_on = 1'b1;
    test_extremes();
    test_special_cases();
    test_random(190, 1'b1);
    test_drain_pause();
    test_random(230, 1'b1);
    test_random(130, 1'b0);
    in_valid_i <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (bad_words == 0 && pending_dates.size() == 0) begin
      $display("[calendar_date_subtract_top] OK");
    end else begin
      $display("[calendar_date_subtract_top] ERROR");
    end
    $finish;
  end

endmodule
